// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the agent RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// general property on the rising edge, held off while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/tqa_pkg.sv =====
// ----------------------------------------------------------------------------
// Q-learning agent package
// Shared types, constants and control structs of the agent block.
// ----------------------------------------------------------------------------
package tqa_pkg;

  localparam int STATES          = 256;
  localparam int ACTIONS_DEF     = 5;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_ONE        = 65536;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [11:0] LVL_ONE_RST   = 12'd500;
  localparam logic [11:0] LVL_TWO_RST   = 12'd1500;
  localparam logic [11:0] LVL_THREE_RST = 12'd2500;
  localparam logic [15:0] ALPHA_RST     = 16'd6554;
  localparam logic [15:0] GAMMA_RST     = 16'd58982;
  localparam logic [16:0] EPS_STEP_RST  = 17'd66;
  localparam logic [16:0] EPS_RST       = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LVL_ONE   = 3'd0,
    CFG_LVL_TWO   = 3'd1,
    CFG_LVL_THREE = 3'd2,
    CFG_ALPHA     = 3'd3,
    CFG_GAMMA     = 3'd4,
    CFG_EPS_STEP  = 3'd5
  } tqa_cfg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_QRD,
    ST_WAIT,
    ST_GQ_LO,
    ST_GQ_HI,
    ST_GQ_SUM,
    ST_DIFF,
    ST_D_LO,
    ST_D_HI,
    ST_D_SUM,
    ST_NV,
    ST_WRITE,
    ST_SCAN,
    ST_OUT
  } tqa_state_e;

  typedef struct packed {
    logic [11:0]       front_right_sample;
    logic [11:0]       right_side_sample;
    logic [11:0]       left_side_sample;
    logic [11:0]       front_left_sample;
    logic signed [7:0] reward;
    logic [15:0]       explore_draw;
    logic [15:0]       action_draw;
  } tqa_in_t;

  typedef struct packed {
    logic [2:0]         chosen_action;
    logic [7:0]         state_index;
    logic               explored;
    logic [16:0]        epsilon_now;
    logic signed [31:0] written_value;
  } tqa_out_t;

  typedef struct packed {
    logic clr_wr;    // clearing pass write
    logic item_ld;   // latch input word
    logic cnt_clr;
    logic row_rd;    // read next entry of the new state's row
    logic q_rd;      // read entry of previous state/action
    logic mul_sel;   // 0: gamma * max, 1: alpha * diff
    logic mul_lo;
    logic mul_hi;
    logic base_ld;
    logic sum_ld;
    logic diff_ld;
    logic nv_ld;
    logic upd_wr;    // table write-back and epsilon decay
    logic scan;      // argmax scan over row buffer
    logic out_ld;
  } tqa_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic clr_last;
    logic have_last;
    logic out_busy;
  } tqa_stat_t;

endpackage

// ===== hdl/tqa_in_if.sv =====
// ----------------------------------------------------------------------------
// Agent input channel
// Valid/ready channel carrying one sensor word per transfer.
// ----------------------------------------------------------------------------
interface tqa_in_if;
  logic              valid;
  logic              ready;
  tqa_pkg::tqa_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/tqa_out_if.sv =====
// ----------------------------------------------------------------------------
// Agent output channel
// Valid/ready channel carrying one decision word per transfer.
// ----------------------------------------------------------------------------
interface tqa_out_if;
  logic              valid;
  logic              ready;
  tqa_pkg::tqa_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/tqa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Agent controller
// Sequences table clear, row read, update arithmetic, write-back and choice.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tqa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tqa_pkg::tqa_stat_t stat_i,
  output tqa_pkg::tqa_cmd_t  cmd_o
);
  import tqa_pkg::*;

  tqa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_ld = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd_o.row_rd = 1'b1;
        if (stat_i.cnt_last) state_d = ST_QRD;
      end
      ST_QRD: begin
        cmd_o.q_rd = 1'b1;
        state_d    = ST_WAIT;
      end
      ST_WAIT: begin
        // last read word lands this cycle; first word skips the update
        if (stat_i.have_last) begin
          state_d = ST_GQ_LO;
        end else begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_GQ_LO: begin
        cmd_o.mul_lo  = 1'b1;
        cmd_o.base_ld = 1'b1;
        state_d       = ST_GQ_HI;
      end
      ST_GQ_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_GQ_SUM;
      end
      ST_GQ_SUM: begin
        cmd_o.sum_ld = 1'b1;
        state_d      = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff_ld = 1'b1;
        state_d       = ST_D_LO;
      end
      ST_D_LO: begin
        cmd_o.mul_sel = 1'b1;
        cmd_o.mul_lo  = 1'b1;
        state_d       = ST_D_HI;
      end
      ST_D_HI: begin
        cmd_o.mul_sel = 1'b1;
        cmd_o.mul_hi  = 1'b1;
        state_d       = ST_D_SUM;
      end
      ST_D_SUM: begin
        cmd_o.sum_ld = 1'b1;
        state_d      = ST_NV;
      end
      ST_NV: begin
        cmd_o.nv_ld = 1'b1;
        state_d     = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.upd_wr  = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        state_d       = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.cnt_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  `ASSERT_CLK(a_accept_leaves_idle, clk_i, rst_ni, in_valid_i && in_ready_o |=> state_q != ST_IDLE, "accepted word did not start processing")
  `ASSERT_IMPLY(a_update_needs_prev, clk_i, rst_ni, cmd_o.upd_wr, stat_i.have_last, "table write without a previous state")

endmodule

// ===== hdl/tqa_datapath.sv =====
// ----------------------------------------------------------------------------
// Agent datapath
// Value table, config registers, quantizer, shared multiplier and output word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tqa_datapath #(
  parameter int ACTIONS     = tqa_pkg::ACTIONS_DEF,
  parameter int VALUE_WIDTH = tqa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tqa_pkg::tqa_cmd_t               cmd_i,
  output tqa_pkg::tqa_stat_t              stat_o,
  input  tqa_pkg::tqa_in_t                in_data_i,
  output tqa_pkg::tqa_out_t               out_data_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic                            cfg_we_i,
  input  logic [tqa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tqa_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tqa_pkg::*;

  localparam int VW    = VALUE_WIDTH;
  localparam int DW    = ((VW > 24) ? VW : 24) + 2;  // update arithmetic width
  localparam int NW    = DW + 1;
  localparam int DEPTH = STATES * ACTIONS;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(ACTIONS);
  localparam int RW    = 17 + KW;

  localparam logic signed [NW-1:0] VMAX = {{(NW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [NW-1:0] VMIN = {{(NW-VW+1){1'b1}}, {(VW-1){1'b0}}};

  function automatic logic [1:0] quant(input logic [11:0] s, input logic [11:0] t1,
                                       input logic [11:0] t2, input logic [11:0] t3);
    logic [1:0] lvl;
    priority if (s < t1) lvl = 2'd0;
    else if (s < t2)     lvl = 2'd1;
    else if (s < t3)     lvl = 2'd2;
    else                 lvl = 2'd3;
    return lvl;
  endfunction

  // config registers
  logic [11:0] lvl1_q, lvl2_q, lvl3_q;
  logic [15:0] alpha_q, gamma_q;
  logic [16:0] eps_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl1_q     <= LVL_ONE_RST;
      lvl2_q     <= LVL_TWO_RST;
      lvl3_q     <= LVL_THREE_RST;
      alpha_q    <= ALPHA_RST;
      gamma_q    <= GAMMA_RST;
      eps_step_q <= EPS_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LVL_ONE:   lvl1_q     <= cfg_data_i[11:0];
        CFG_LVL_TWO:   lvl2_q     <= cfg_data_i[11:0];
        CFG_LVL_THREE: lvl3_q     <= cfg_data_i[11:0];
        CFG_ALPHA:     alpha_q    <= cfg_data_i[15:0];
        CFG_GAMMA:     gamma_q    <= cfg_data_i[15:0];
        CFG_EPS_STEP:  eps_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item registers
  logic [7:0]        st_q;
  logic signed [7:0] rew_q;
  logic [15:0]       edraw_q, adraw_q;
  logic [7:0]        st_d;

  assign st_d = {quant(in_data_i.front_left_sample, lvl1_q, lvl2_q, lvl3_q),
                 quant(in_data_i.left_side_sample, lvl1_q, lvl2_q, lvl3_q),
                 quant(in_data_i.right_side_sample, lvl1_q, lvl2_q, lvl3_q),
                 quant(in_data_i.front_right_sample, lvl1_q, lvl2_q, lvl3_q)};

  // control state
  logic          have_last_q;
  logic [7:0]    last_state_q;
  logic [KW-1:0] last_action_q;
  logic [16:0]   eps_q;
  logic          out_valid_q;
  logic [KW-1:0] cnt_q;
  logic [AW-1:0] clr_q;
  logic          cap_row_q, cap_first_q, cap_qv_q;

  // payload
  logic signed [VW-1:0] mem [DEPTH];
  logic signed [VW-1:0] rd_data_q;
  logic signed [VW-1:0] row_buf_q [ACTIONS];
  logic signed [VW-1:0] best_q, q_q, nv_q;
  logic [KW-1:0]        best_a_q;
  logic [31:0]          p_lo_q;
  logic signed [DW:0]   p_hi_q;
  logic signed [DW-1:0] sum_q, base_q, diff_q;
  logic signed [31:0]   written_q;
  tqa_out_t             out_q;

  // addressing
  logic [AW-1:0] row_addr, last_addr, wr_addr, rd_addr;
  logic          mem_we, mem_re;
  logic [VW-1:0] wr_data;

  assign row_addr  = AW'(st_q) * AW'(ACTIONS) + AW'(cnt_q);
  assign last_addr = AW'(last_state_q) * AW'(ACTIONS) + AW'(last_action_q);
  assign mem_we    = cmd_i.clr_wr | cmd_i.upd_wr;
  assign wr_addr   = cmd_i.clr_wr ? clr_q : last_addr;
  assign wr_data   = cmd_i.clr_wr ? '0 : nv_q;
  assign mem_re    = cmd_i.row_rd | cmd_i.q_rd;
  assign rd_addr   = cmd_i.row_rd ? row_addr : last_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rd_data_q <= mem[rd_addr];
  end

  // shared fractional multiplier: floor(frac * x / 2^16) in two partial products
  logic [15:0]           frac_sel;
  logic signed [DW-1:0]  mul_x;
  logic signed [DW-17:0] mul_xh;
  logic signed [DW:0]    sum_w;
  logic signed [NW-1:0]  nv_w;
  logic signed [VW-1:0]  nv_sat;

  assign frac_sel = cmd_i.mul_sel ? alpha_q : gamma_q;
  assign mul_x    = cmd_i.mul_sel ? diff_q : DW'(best_q);
  assign mul_xh   = mul_x[DW-1:16];
  assign sum_w    = p_hi_q + $signed({{(DW-15){1'b0}}, p_lo_q[31:16]});
  assign nv_w     = NW'(q_q) + NW'(sum_q);

  always_comb begin
    if (nv_w > VMAX)      nv_sat = VMAX[VW-1:0];
    else if (nv_w < VMIN) nv_sat = VMIN[VW-1:0];
    else                  nv_sat = nv_w[VW-1:0];
  end

  // action choice
  logic          explore;
  logic [RW-1:0] rnd_prod;
  logic [KW-1:0] action_sel;

  assign explore    = (18'(edraw_q) + 18'(eps_q)) > 18'(FRAC_ONE);
  assign rnd_prod   = RW'(adraw_q) * RW'(ACTIONS);
  assign action_sel = explore ? rnd_prod[16 +: KW] : best_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_last_q   <= 1'b0;
      last_state_q  <= '0;
      last_action_q <= '0;
      eps_q         <= EPS_RST;
      out_valid_q   <= 1'b0;
      cnt_q         <= '0;
      clr_q         <= '0;
      cap_row_q     <= 1'b0;
      cap_first_q   <= 1'b0;
      cap_qv_q      <= 1'b0;
    end else begin
      cap_row_q   <= cmd_i.row_rd;
      cap_first_q <= cmd_i.row_rd && (cnt_q == '0);
      cap_qv_q    <= cmd_i.q_rd;
      if (cmd_i.clr_wr) clr_q <= clr_q + 1'b1;
      if (cmd_i.cnt_clr)                    cnt_q <= '0;
      else if (cmd_i.row_rd || cmd_i.scan)  cnt_q <= cnt_q + 1'b1;
      if (cmd_i.upd_wr) begin
        eps_q <= (eps_q >= eps_step_q) ? eps_q - eps_step_q : '0;
      end
      if (cmd_i.out_ld) begin
        have_last_q   <= 1'b1;
        last_state_q  <= st_q;
        last_action_q <= action_sel;
      end
      out_valid_q <= cmd_i.out_ld | (out_valid_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_ld) begin
      st_q      <= st_d;
      rew_q     <= in_data_i.reward;
      edraw_q   <= in_data_i.explore_draw;
      adraw_q   <= in_data_i.action_draw;
      written_q <= '0;
    end
    // row words shift in at the top, so entry a ends up at slot a
    if (cap_row_q) begin
      for (int i = 0; i < ACTIONS - 1; i++) row_buf_q[i] <= row_buf_q[i+1];
      row_buf_q[ACTIONS-1] <= rd_data_q;
      if (cap_first_q || rd_data_q > best_q) best_q <= rd_data_q;
    end
    if (cap_qv_q) q_q <= rd_data_q;
    // argmax: rotate the buffer past slot 0, strict compare keeps lowest index
    if (cmd_i.scan) begin
      for (int i = 0; i < ACTIONS - 1; i++) row_buf_q[i] <= row_buf_q[i+1];
      row_buf_q[ACTIONS-1] <= row_buf_q[0];
      if (cnt_q == '0 || row_buf_q[0] > best_q) begin
        best_q   <= row_buf_q[0];
        best_a_q <= cnt_q;
      end
    end
    if (cmd_i.mul_lo)  p_lo_q <= 32'(frac_sel) * 32'(mul_x[15:0]);
    if (cmd_i.mul_hi)  p_hi_q <= (DW+1)'($signed({1'b0, frac_sel})) * (DW+1)'(mul_xh);
    if (cmd_i.sum_ld)  sum_q  <= DW'(sum_w);
    if (cmd_i.base_ld) base_q <= ($signed(DW'(rew_q)) <<< 16) - DW'(q_q);
    if (cmd_i.diff_ld) diff_q <= base_q + sum_q;
    if (cmd_i.nv_ld)   nv_q   <= nv_sat;
    if (cmd_i.upd_wr) begin
      written_q <= 32'(nv_q);
      // same state revisited: argmax must see the fresh entry
      if (last_state_q == st_q) row_buf_q[last_action_q] <= nv_q;
    end
    if (cmd_i.out_ld) begin
      out_q.chosen_action <= 3'(action_sel);
      out_q.state_index   <= st_q;
      out_q.explored      <= explore;
      out_q.epsilon_now   <= eps_q;
      out_q.written_value <= written_q;
    end
  end

  assign stat_o.cnt_last  = (cnt_q == KW'(ACTIONS - 1));
  assign stat_o.clr_last  = (clr_q == AW'(DEPTH - 1));
  assign stat_o.have_last = have_last_q;
  assign stat_o.out_busy  = out_valid_q & ~out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_CLK(a_eps_no_rise, clk_i, rst_ni, 1'b1 |=> eps_q <= $past(eps_q), "epsilon increased")
  `ASSERT_IMPLY(a_first_writes_zero, clk_i, rst_ni, cmd_i.out_ld && !have_last_q, written_q == '0, "first word reports a nonzero write")

endmodule

// ===== hdl/tabular_q_learning_agent_unit.sv =====
// ----------------------------------------------------------------------------
// Tabular Q-learning agent
// Epsilon-greedy agent over a 256-state table with in-place value update.
// ----------------------------------------------------------------------------
// One input word (four distance samples, reward, two random draws) yields one
// output word. The next word is accepted only after the previous one has been
// loaded into the output register. With a previous state/action pair a word
// updates the table first; the first word after reset skips the update.
// The time a word takes comes from three things:
//   - the serial table read of the row, one entry per cycle;
//   - the shared two-pass fractional multiplier used for gamma and alpha;
//   - the serial argmax over the row.
// A stalled output channel makes the controller wait before loading the output.
// After reset the table is zeroed by a clearing pass over all STATES*ACTIONS
// entries, during which no word is accepted; configuration writes are taken at
// any time. A finished word waits in the output register while the next input
// word is accepted.
module tabular_q_learning_agent_unit #(
  parameter int ACTIONS     = tqa_pkg::ACTIONS_DEF,
  parameter int VALUE_WIDTH = tqa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tqa_in_if.sink                         in_i,
  tqa_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [tqa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tqa_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tqa_pkg::*;

  tqa_cmd_t  cmd;
  tqa_stat_t stat;
  logic      in_ready;
  logic      out_valid;
  tqa_out_t  out_data;

  tqa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tqa_datapath #(
    .ACTIONS     (ACTIONS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_i.data),
    .out_data_o  (out_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule
